// ===== rtl/core/dlmb_pkg.sv =====
// ----------------------------------------------------------------------------
// dlmb_pkg
// Shared types and codes for the dense layer matrix-vector core.
// ----------------------------------------------------------------------------
package dlmb_pkg;

	// Data word width, signed with 8 fraction bits
	localparam int DATA_WIDTH = 16;

	// Field types of the load and result beats and the configuration port
	typedef logic        [1:0]            req_t;
	typedef logic        [3:0]            idx_t;
	typedef logic signed [DATA_WIDTH-1:0] q88_t;
	typedef logic        [4:0]            cnt_t;
	typedef logic        [0:0]            cfg_idx_t;

	// Request codes
	localparam req_t REQ_WEIGHT = 2'd0;
	localparam req_t REQ_BIAS   = 2'd1;
	localparam req_t REQ_INPUT  = 2'd2;

	// Configuration register indexes
	localparam cfg_idx_t CFG_IN_COUNT  = 1'd0;
	localparam cfg_idx_t CFG_OUT_COUNT = 1'd1;

	// Count registers come out of reset at 16
	localparam cnt_t CNT_RESET = 5'd16;

	// Fraction bits of the Q8.8 format
	localparam int FRAC_BITS = 8;

endpackage

// ===== rtl/core/dense_layer_matvec_bias.sv =====
// ----------------------------------------------------------------------------
// dense_layer_matvec_bias
// Fully connected layer core: bias plus matrix-vector product, Q8.8 results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries load beats: a weight word at
//   (row_index, col_index), a bias word at row_index, or an input element at
//   col_index. Loads are taken one per cycle while the core is idle; request
//   code 3 and out-of-range indexes are dropped.
//   An input element with last_element set is stored, then starts the layer:
//   rows 0 .. out_count-1 are computed in order and sent on the output
//   channel (out_valid/out_ready), one beat per row, last_row on the final.
//   Each row runs on the single MAC: one bias read, then one weight/element
//   read per column from the coefficient and vector RAMs, passing through
//   the registered read, product and accumulate stages. in_ready stays low
//   until the last row is loaded into the output register.
//   A result waits in the output register while the receiver stalls; the
//   next row is computed meanwhile and held until that register frees up.
//   Reset clears control only: counts return to 16, stores hold garbage
//   until written. cfg_we writes in_count (index 0) or out_count (index 1).
// ----------------------------------------------------------------------------
module dense_layer_matvec_bias #(
	parameter int IN_DIM     = 16,
	parameter int OUT_DIM    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  dlmb_pkg::cfg_idx_t  cfg_index,
	input  dlmb_pkg::cnt_t      cfg_data,
	// load beats
	input  logic                in_valid,
	output logic                in_ready,
	input  dlmb_pkg::req_t      req_type,
	input  dlmb_pkg::idx_t      row_index,
	input  dlmb_pkg::idx_t      col_index,
	input  dlmb_pkg::q88_t      data_value,
	input  logic                last_element,
	// result beats
	output logic                out_valid,
	input  logic                out_ready,
	output dlmb_pkg::idx_t      out_row,
	output dlmb_pkg::q88_t      out_value,
	output logic                clipped,
	output logic                last_row
);

	import dlmb_pkg::*;

	localparam int CW      = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
	localparam int RW      = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
	localparam int W_DEPTH = OUT_DIM * IN_DIM;
	localparam int C_DEPTH = W_DEPTH + OUT_DIM;
	localparam int CAW     = $clog2(C_DEPTH);
	// accumulator: product width plus growth for IN_DIM terms and the bias,
	// capped at 64 bits (wraps there)
	localparam int AW      = (2 * DATA_WIDTH + CW + 2 > 64) ? 64 : 2 * DATA_WIDTH + CW + 2;

	localparam logic [CAW-1:0] BIAS_BASE = CAW'(W_DEPTH);
	localparam logic [CAW-1:0] ROW_STEP  = CAW'(IN_DIM);
	localparam longint SAT_MAX_L = (longint'(1) << (DATA_WIDTH - 1)) - 1;
	localparam logic signed [AW-1:0] SAT_MAX = AW'(SAT_MAX_L);
	localparam logic signed [AW-1:0] SAT_MIN = AW'(-SAT_MAX_L - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_BIAS = 4'b0010,
		ST_MAC  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	cnt_t in_count_q;
	cnt_t out_count_q;

	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [CAW-1:0] addr_q;
	logic [CAW-1:0] base_q;
	logic           fin_ok_q;

	logic [CW-1:0] ni_m1;
	logic [RW-1:0] no_m1;

	logic in_acc;
	logic iss_vld;
	logic iss_bias;
	logic iss_last;
	logic emit;

	// RAM ports
	logic                  coef_we;
	logic [CAW-1:0]        coef_waddr;
	logic [CAW-1:0]        coef_raddr;
	logic [DATA_WIDTH-1:0] coef_rd;
	logic                  vec_we;
	logic [CW-1:0]         vec_waddr;
	logic [DATA_WIDTH-1:0] vec_rd;
	logic [DATA_WIDTH-1:0] wdata;

	// MAC pipeline
	logic                       vld_s1;
	logic                       bias_s1;
	logic                       lastc_s1;
	logic                       vld_s2;
	logic                       first_s2;
	logic                       lastc_s2;
	logic signed [AW-1:0]       term_s2;
	logic signed [AW-1:0]       acc_q;
	logic                       done_s3;
	logic signed [2*DATA_WIDTH-1:0] prod;
	logic signed [AW-1:0]       term;

	// Result stage
	logic signed [AW-1:0] acc_sh;
	logic signed [AW-1:0] res;
	logic                 sat;
	logic [31:0]          row_ext;

	logic out_valid_q;
	idx_t out_row_q;
	q88_t out_value_q;
	logic clipped_q;
	logic last_row_q;

	// ------------------------------------------------------------------
	// Clamped counts, kept as last index
	// ------------------------------------------------------------------
	always_comb begin
		if (in_count_q == '0) begin
			ni_m1 = '0;
		end else if (32'(in_count_q) > IN_DIM) begin
			ni_m1 = CW'(IN_DIM - 1);
		end else begin
			ni_m1 = CW'(in_count_q - 5'd1);
		end
		if (out_count_q == '0) begin
			no_m1 = '0;
		end else if (32'(out_count_q) > OUT_DIM) begin
			no_m1 = RW'(OUT_DIM - 1);
		end else begin
			no_m1 = RW'(out_count_q - 5'd1);
		end
	end

	// ------------------------------------------------------------------
	// Load path: weights and biases share the coefficient RAM, biases
	// sit above the weight matrix
	// ------------------------------------------------------------------
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign wdata    = data_value;
	assign vec_waddr = CW'(col_index);

	always_comb begin
		coef_we    = 1'b0;
		coef_waddr = '0;
		vec_we     = 1'b0;
		if (in_acc) begin
			case (req_type)
				REQ_WEIGHT: begin
					if (32'(row_index) < OUT_DIM && 32'(col_index) < IN_DIM) begin
						coef_we    = 1'b1;
						coef_waddr = CAW'(32'(row_index) * IN_DIM + 32'(col_index));
					end
				end
				REQ_BIAS: begin
					if (32'(row_index) < OUT_DIM) begin
						coef_we    = 1'b1;
						coef_waddr = BIAS_BASE + CAW'(row_index);
					end
				end
				REQ_INPUT: begin
					vec_we = (32'(col_index) < IN_DIM);
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Read issue: one bias read, then one weight and element per column
	// ------------------------------------------------------------------
	assign iss_bias   = (state_q == ST_BIAS);
	assign iss_vld    = iss_bias || (state_q == ST_MAC);
	assign iss_last   = (state_q == ST_MAC) && (col_q == ni_m1);
	assign coef_raddr = iss_bias ? (BIAS_BASE + CAW'(row_q)) : addr_q;

	dlmb_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(C_DEPTH)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(coef_waddr),
		.wdata(wdata),
		.raddr(coef_raddr),
		.rdata(coef_rd)
	);

	dlmb_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(IN_DIM)
	) u_vec_ram (
		.clk  (clk),
		.we   (vec_we),
		.waddr(vec_waddr),
		.wdata(wdata),
		.raddr(col_q),
		.rdata(vec_rd)
	);

	// ------------------------------------------------------------------
	// MAC: s1 = RAM data, s2 = product or aligned bias, then accumulate
	// ------------------------------------------------------------------
	assign prod = $signed(coef_rd) * $signed(vec_rd);
	assign term = bias_s1 ? (AW'($signed(coef_rd)) <<< FRAC_BITS) : AW'(prod);

	always_ff @(posedge clk) begin
		bias_s1  <= iss_bias;
		lastc_s1 <= iss_last;
		term_s2  <= term;
		first_s2 <= bias_s1;
		lastc_s2 <= lastc_s1;
		if (vld_s2) begin
			acc_q <= first_s2 ? term_s2 : acc_q + term_s2;
		end
	end

	// ------------------------------------------------------------------
	// Result: drop the fraction (floor), saturate to DATA_WIDTH
	// ------------------------------------------------------------------
	assign acc_sh  = acc_q >>> FRAC_BITS;
	assign row_ext = 32'(row_q);

	always_comb begin
		sat = 1'b0;
		res = acc_sh;
		if (acc_sh > SAT_MAX) begin
			res = SAT_MAX;
			sat = 1'b1;
		end else if (acc_sh < SAT_MIN) begin
			res = SAT_MIN;
			sat = 1'b1;
		end
	end

	assign emit = (state_q == ST_FIN) && (done_s3 || fin_ok_q) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row_q   <= row_ext[3:0];
			out_value_q <= res[DATA_WIDTH-1:0];
			clipped_q   <= sat;
			last_row_q  <= (row_q == no_m1);
		end
	end

	// ------------------------------------------------------------------
	// Control
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_count_q  <= CNT_RESET;
			out_count_q <= CNT_RESET;
			row_q       <= '0;
			col_q       <= '0;
			addr_q      <= '0;
			base_q      <= '0;
			fin_ok_q    <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			done_s3     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IN_COUNT:  in_count_q  <= cfg_data;
					CFG_OUT_COUNT: out_count_q <= cfg_data;
					default: begin
					end
				endcase
			end

			vld_s1  <= iss_vld;
			vld_s2  <= vld_s1;
			done_s3 <= vld_s2 && lastc_s2;

			if (emit) begin
				fin_ok_q <= 1'b0;
			end else if (done_s3) begin
				fin_ok_q <= 1'b1;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && req_type == REQ_INPUT && last_element) begin
						row_q   <= '0;
						base_q  <= '0;
						state_q <= ST_BIAS;
					end
				end
				ST_BIAS: begin
					col_q   <= '0;
					addr_q  <= base_q;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (iss_last) begin
						state_q <= ST_FIN;
					end else begin
						col_q  <= col_q + 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (emit) begin
						if (row_q == no_m1) begin
							state_q <= ST_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							base_q  <= base_q + ROW_STEP;
							state_q <= ST_BIAS;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_value = out_value_q;
	assign clipped   = clipped_q;
	assign last_row  = last_row_q;

endmodule

// ===== rtl/core/dlmb_ram.sv =====
// ----------------------------------------------------------------------------
// dlmb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dlmb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== dv/tb_dense_layer_matvec_bias.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dense_layer_matvec_bias
// Self-checking bench for the dense layer core. Load beats come from a queue
// through a bursty driver. A predictor mirrors the weight, bias and vector
// stores and works out every row of each layer pass. A monitor checks each
// result beat against the oldest predicted row while the receiver stalls at
// random.
// ----------------------------------------------------------------------------
module tb_dense_layer_matvec_bias;
	import dlmb_pkg::*;

	localparam int N_IN  = 16;
	localparam int N_OUT = 16;

	// code 3 is not a load; the core must drop it
	localparam req_t REQ_UNUSED = 2'd3;

	// A layer pass is at most 16 rows of 16 columns. Add receiver stalls
	// and the pauses between phases, and nothing near this many quiet cycles
	// happens in a healthy run.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 30;   // quiet time before a count write
	localparam int TAIL_CYCLES    = 400;  // covers one full 16x16 pass
	localparam int PHASE_LOADS    = 6;    // minimum of load beats per count setting
	localparam int N_PHASES       = 7;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		req_t kind;
		idx_t row;
		idx_t col;
		q88_t value;
		logic last;
	} load_beat_t;

	typedef struct packed {
		idx_t row;
		q88_t value;
		logic clip;
		logic last;
	} row_result_t;

	// receiver behavior for out_ready, re-picked at random
	typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_t;

	// ------------------------------------------------------------------
	// DUT signals; every input has a known value from time zero
	// ------------------------------------------------------------------
	logic     clk;
	logic     arst_n       = 1'b0;
	logic     cfg_we       = 1'b0;
	cfg_idx_t cfg_index    = CFG_IN_COUNT;
	cnt_t     cfg_data     = '0;
	logic     in_valid     = 1'b0;
	logic     in_ready;
	req_t     req_type     = REQ_WEIGHT;
	idx_t     row_index    = '0;
	idx_t     col_index    = '0;
	q88_t     data_value   = '0;
	logic     last_element = 1'b0;
	logic     out_valid;
	logic     out_ready    = 1'b0;
	idx_t     out_row;
	q88_t     out_value;
	logic     clipped;
	logic     last_row;

	dense_layer_matvec_bias u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.row_index   (row_index),
		.col_index   (col_index),
		.data_value  (data_value),
		.last_element(last_element),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_row     (out_row),
		.out_value   (out_value),
		.clipped     (clipped),
		.last_row    (last_row)
	);

	// ------------------------------------------------------------------
	// Predictor state: mirror of the stores and the count registers
	// ------------------------------------------------------------------
	q88_t weight_mem [N_OUT*N_IN];
	q88_t bias_mem   [N_OUT];
	q88_t vector_mem [N_IN];
	cnt_t in_count_reg  = CNT_RESET;
	cnt_t out_count_reg = CNT_RESET;

	row_result_t expected_rows[$];   // rows predicted, not yet seen
	load_beat_t  pending_loads[$];   // beats waiting for the driver

	// Stimulus side bookkeeping: which entries hold a written value.
	// A pass never starts while an entry it reads is still unwritten.
	bit weight_seen [N_OUT*N_IN];
	bit bias_seen   [N_OUT];
	bit vector_seen [N_IN];

	// count settings per phase; 0, 17 and 31 check the clamping
	cnt_t phase_in  [N_PHASES] = '{5'd3, 5'd16, 5'd1,  5'd0, 5'd7,  5'd31, 5'd16};
	cnt_t phase_out [N_PHASES] = '{5'd5, 5'd1,  5'd16, 5'd2, 5'd17, 5'd31, 5'd16};

	int fail_count     = 0;
	int loads_queued   = 0;   // beats the core acts on (code 3 not counted)
	int passes_queued  = 0;
	int beats_accepted = 0;
	int rows_checked   = 0;
	int idle_cycles    = 0;
	int gap_left       = 0;
	int burst_left     = 0;
	int mode_cycles    = 0;
	sink_mode_t ready_mode = SINK_OPEN;

	load_beat_t  next_load;
	load_beat_t  seen_load;
	row_result_t want_row;
	row_result_t got_row;

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// counts outside 1..top are clamped by the core when a pass starts
	function automatic int used_count(cnt_t c, int top);
		if (c == 0)
			return 1;
		if (c > top)
			return top;
		return c;
	endfunction

	// Half the time small Q8.8 values so sums stay in range, else the corners
	// or full-range noise that drives saturation.
	function automatic q88_t pick_value();
		int v;
		case ($urandom_range(0, 7))
		0: begin
			case ($urandom_range(0, 3))
			0:       v = 32'h8000;
			1:       v = 32'h7fff;
			2:       v = 0;
			default: v = 32'hffff;
			endcase
		end
		1, 2, 3, 4: v = $urandom_range(0, 1023) - 512;
		default:    v = $urandom();
		endcase
		return q88_t'(v);
	endfunction

	// ------------------------------------------------------------------
	// Predictor: store the beat; a last input element runs the layer.
	// Per row: bias aligned to Q16.16, plus the Q16.16 products, then an
	// arithmetic shift by FRAC_BITS (drops low bits, rounds toward -inf)
	// and saturation to 16 bits.
	// ------------------------------------------------------------------
	function automatic void apply_load(load_beat_t b);
		int          n_in;
		int          n_out;
		longint      acc;
		longint      q;
		row_result_t res;
		case (b.kind)
		REQ_WEIGHT: weight_mem[b.row*N_IN + b.col] = b.value;
		REQ_BIAS:   bias_mem[b.row] = b.value;
		REQ_INPUT:  vector_mem[b.col] = b.value;
		default:    ;
		endcase
		if (b.kind != REQ_INPUT || !b.last)
			return;
		n_in  = used_count(in_count_reg, N_IN);
		n_out = used_count(out_count_reg, N_OUT);
		for (int r = 0; r < n_out; r++) begin
			acc = longint'(bias_mem[r]) <<< FRAC_BITS;
			for (int c = 0; c < n_in; c++)
				acc += longint'(weight_mem[r*N_IN + c]) * longint'(vector_mem[c]);
			q = acc >>> FRAC_BITS;
			res.row  = idx_t'(r);
			res.clip = 1'b0;
			if (q > 32767) begin
				res.value = 16'sh7fff;
				res.clip  = 1'b1;
			end else if (q < -32768) begin
				res.value = 16'sh8000;
				res.clip  = 1'b1;
			end else begin
				res.value = q88_t'(q);
			end
			res.last = (r == n_out - 1);
			expected_rows.push_back(res);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers. They run at a falling edge, so the driver never
	// sees the queue change in the middle of its own edge.
	// ------------------------------------------------------------------
	task automatic push_load(req_t kind, idx_t row, idx_t col, q88_t value, logic last);
		load_beat_t b;
		b = '{kind, row, col, value, last};
		pending_loads.push_back(b);
		case (kind)
		REQ_WEIGHT: weight_seen[row*N_IN + col] = 1'b1;
		REQ_BIAS:   bias_seen[row] = 1'b1;
		REQ_INPUT:  vector_seen[col] = 1'b1;
		default:    ;
		endcase
		if (kind != REQ_UNUSED)
			loads_queued++;
		if (kind == REQ_INPUT && last)
			passes_queued++;
	endtask

	// Fill every entry the pass will read that is still unwritten, then
	// send the last input element that starts the pass.
	task automatic fire_layer();
		int n_in;
		int n_out;
		n_in  = used_count(in_count_reg, N_IN);
		n_out = used_count(out_count_reg, N_OUT);
		for (int r = 0; r < n_out; r++)
			for (int c = 0; c < n_in; c++)
				if (!weight_seen[r*N_IN + c])
					push_load(REQ_WEIGHT, idx_t'(r), idx_t'(c), pick_value(), 1'b0);
		for (int r = 0; r < n_out; r++)
			if (!bias_seen[r])
				push_load(REQ_BIAS, idx_t'(r), idx_t'($urandom), pick_value(), 1'b0);
		for (int c = 0; c < n_in; c++)
			if (!vector_seen[c])
				push_load(REQ_INPUT, idx_t'($urandom), idx_t'(c), pick_value(), 1'b0);
		push_load(REQ_INPUT, idx_t'($urandom), idx_t'($urandom_range(0, N_IN - 1)),
			pick_value(), 1'b1);
	endtask

	// A few reloads with random content, mostly inside the rows and columns
	// in use, some noise, and usually a start at the end. Passes left
	// without a start carry their loads into the next one.
	task automatic random_pass();
		int   n_in;
		int   n_out;
		idx_t r;
		idx_t c;
		n_in  = used_count(in_count_reg, N_IN);
		n_out = used_count(out_count_reg, N_OUT);
		repeat ($urandom_range(0, 12)) begin
			r = ($urandom_range(0, 3) == 0) ? idx_t'($urandom) : idx_t'($urandom_range(0, n_out - 1));
			c = ($urandom_range(0, 3) == 0) ? idx_t'($urandom) : idx_t'($urandom_range(0, n_in - 1));
			case ($urandom_range(0, 9))
			0, 1, 2, 3: push_load(REQ_WEIGHT, r, c, pick_value(), 1'b0);
			4, 5:       push_load(REQ_BIAS, r, idx_t'($urandom), pick_value(), 1'b0);
			6, 7:       push_load(REQ_INPUT, idx_t'($urandom), c, pick_value(), 1'b0);
			8:          push_load(REQ_UNUSED, idx_t'($urandom), idx_t'($urandom),
					q88_t'($urandom), 1'($urandom));
			default:    push_load(($urandom_range(0, 1) != 0) ? REQ_BIAS : REQ_WEIGHT,
					r, c, pick_value(), 1'b1);
			endcase
		end
		if ($urandom_range(0, 5) != 0)
			fire_layer();
	endtask

	// Block until every queued beat went in and every predicted row came
	// out, then give the core a little quiet time.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_loads.size() != 0 || in_valid || expected_rows.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(cfg_idx_t idx, cnt_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IN_COUNT)
			in_count_reg = value;
		else
			out_count_reg = value;
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of beats with random gaps. Valid only drops after a
	// beat is taken, and the payload holds while it waits.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_loads.size() != 0) begin
				next_load = pending_loads.pop_front();
				req_type     <= next_load.kind;
				row_index    <= next_load.row;
				col_index    <= next_load.col;
				data_value   <= next_load.value;
				last_element <= next_load.last;
				in_valid     <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					// new burst; three times in eight back to back, now and
					// then a long gap
					burst_left = $urandom_range(0, 24);
					case ($urandom_range(0, 7))
					0, 1, 2: gap_left = 0;
					7:       gap_left = $urandom_range(10, 30);
					default: gap_left = $urandom_range(1, 4);
					endcase
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// every accepted load beat goes through the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			seen_load = '{req_type, row_index, col_index, data_value, last_element};
			apply_load(seen_load);
			beats_accepted++;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: open, choppy or slow, switching mode at random
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_cycles == 0) begin
				ready_mode  = sink_mode_t'($urandom_range(0, 2));
				mode_cycles = $urandom_range(50, 300);
			end else begin
				mode_cycles--;
			end
			case (ready_mode)
			SINK_OPEN:   out_ready <= 1'b1;
			SINK_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
			default:     out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result checker: each beat against the oldest predicted row
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			rows_checked++;
			got_row = '{out_row, out_value, clipped, last_row};
			if (expected_rows.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result beat for row %0d with no row predicted",
						$time, out_row);
			end else begin
				want_row = expected_rows.pop_front();
				if (got_row !== want_row) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display({"%0t: row beat differs: expected row %0d value %h clip %b ",
							"last %b, got row %0d value %h clip %b last %b"}, $time,
							want_row.row, want_row.value, want_row.clip, want_row.last,
							got_row.row, got_row.value, got_row.clip, got_row.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with no beat on either channel ends the run
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int phase_start;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part on a 1x1 layer: only weight 0,0, bias 0 and element 0
		// are read, so a handful of loads keep every read defined.
		write_count(CFG_IN_COUNT, 5'd1);
		write_count(CFG_OUT_COUNT, 5'd1);
		@(negedge clk);
		// plain pass: 1.0 * 2.0 + 0.5
		push_load(REQ_WEIGHT, 4'd0, 4'd0, 16'sh0100, 1'b0);
		push_load(REQ_BIAS,   4'd0, 4'd0, 16'sh0080, 1'b0);
		push_load(REQ_INPUT,  4'd0, 4'd0, 16'sh0200, 1'b1);
		// last flag on weight and bias loads does nothing
		push_load(REQ_WEIGHT, 4'd0, 4'd0, 16'sh8000, 1'b1);
		push_load(REQ_BIAS,   4'd0, 4'd0, 16'sh7fff, 1'b1);
		// most negative squared: clips high; times max positive: clips low
		push_load(REQ_INPUT,  4'd0, 4'd0, 16'sh8000, 1'b1);
		push_load(REQ_INPUT,  4'd0, 4'd0, 16'sh7fff, 1'b1);
		// unknown request code is dropped, last flag or not
		push_load(REQ_UNUSED, 4'd15, 4'd15, 16'shffff, 1'b1);
		push_load(REQ_UNUSED, 4'd0,  4'd0,  16'sh0000, 1'b0);
		// top row and column, outside the 1x1 layer in use
		push_load(REQ_WEIGHT, 4'd15, 4'd15, 16'shffff, 1'b0);
		push_load(REQ_BIAS,   4'd15, 4'd15, 16'sh0000, 1'b0);
		push_load(REQ_INPUT,  4'd15, 4'd15, 16'sh5a5a, 1'b0);
		// truncation: a product of -1 LSB stays -1, +255 LSB drops to 0
		push_load(REQ_WEIGHT, 4'd0, 4'd0, 16'sh0001, 1'b0);
		push_load(REQ_BIAS,   4'd0, 4'd0, 16'sh0000, 1'b0);
		push_load(REQ_INPUT,  4'd0, 4'd0, 16'shffff, 1'b1);
		push_load(REQ_INPUT,  4'd0, 4'd0, 16'sh00ff, 1'b1);
		// bias alone at both ends of the range: no clipping
		push_load(REQ_BIAS,   4'd0, 4'd0, 16'sh7fff, 1'b0);
		push_load(REQ_INPUT,  4'd0, 4'd0, 16'sh0000, 1'b1);
		push_load(REQ_BIAS,   4'd0, 4'd0, 16'sh8000, 1'b0);
		push_load(REQ_INPUT,  4'd0, 4'd0, 16'sh0000, 1'b1);

		// Random part, one count setting per phase. Counts only change once
		// the core has gone quiet.
		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			write_count(CFG_IN_COUNT, phase_in[p]);
			write_count(CFG_OUT_COUNT, phase_out[p]);
			phase_start = loads_queued;
			while (loads_queued - phase_start < PHASE_LOADS) begin
				@(negedge clk);
				random_pass();
			end
			// once, stop feeding before the closing start and let the core
			// run dry
			if (p == 3)
				wait_drained();
			@(negedge clk);
			fire_layer();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_rows.size() != 0) begin
			$display("%0d predicted rows never came out", expected_rows.size());
			fail_count += expected_rows.size();
		end

		$display("Sent %0d load beats with %0d layer starts; checked %0d result rows.",
			beats_accepted, passes_queued, rows_checked);
		$display("Count settings: 1x1 plus %0d more, clamped values and 16x16 included.",
			N_PHASES);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/dlmb_pkg.sv
rtl/core/dlmb_ram.sv
rtl/core/dense_layer_matvec_bias.sv
dv/tb_dense_layer_matvec_bias.sv
